FILE: hdl/pidpc_pkg.sv
// ----------------------------------------------------------------------------
// pidpc_pkg
// Shared widths, register map and reset values of the positional PID block.
// ----------------------------------------------------------------------------
package pidpc_pkg;

  localparam int SAMPLE_WIDTH_DEF  = 16;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int DATA_W    = 32;
  localparam int STEP_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER     = 3'd5;

  localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

  localparam logic [STEP_W-1:0] STEP_TIME_RST = 16'hFFFF;

endpackage

FILE: hdl/pidpc_sample_if.sv
// ----------------------------------------------------------------------------
// pidpc_sample_if
// Request channel carrying one target / measured pair.
// ----------------------------------------------------------------------------
interface pidpc_sample_if #(
  parameter int SAMPLE_WIDTH = pidpc_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] target;
  logic signed [SAMPLE_WIDTH-1:0] measured;

  modport source (output valid, output target, output measured, input ready);
  modport sink   (input valid, input target, input measured, output ready);
endinterface

FILE: hdl/pidpc_result_if.sv
// ----------------------------------------------------------------------------
// pidpc_result_if
// Result channel carrying the clamped drive value.
// ----------------------------------------------------------------------------
interface pidpc_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pidpc_pkg::DATA_W-1:0]   drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

FILE: hdl/pid_positional_clamped.sv
// ----------------------------------------------------------------------------
// pid_positional_clamped
// Positional PID controller with clamped integral and clamped drive, built
// around one bit-serial shift-add multiplier.
// ----------------------------------------------------------------------------
// Requests are taken only in the idle state. The work is done by the single
// shift-add multiplier, which retires one multiplier bit per cycle over three
// products: error times step time (17 bits), integral gain times integral
// (32 bits), and the proportional and derivative terms together
// (SAMPLE_WIDTH + 2 bits). The drive leaves through an output register, so a
// finished result may wait on the result channel while the next request is
// accepted and worked on. Gains, step time and limits are written through the
// configuration port; the user must write them only while the block is idle,
// as the block itself does not enforce this. No clearing pass after reset.
// ----------------------------------------------------------------------------
module pid_positional_clamped #(
  parameter int SAMPLE_WIDTH  = pidpc_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRACTION_BITS = pidpc_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pidpc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pidpc_pkg::DATA_W-1:0]      cfg_data_i,
  pidpc_sample_if.sink                      sample_i,
  pidpc_result_if.source                    result_o
);

  localparam int DATA_W = pidpc_pkg::DATA_W;
  localparam int STEP_W = pidpc_pkg::STEP_W;
  localparam int ERR_W  = SAMPLE_WIDTH + 1;
  localparam int DERR_W = SAMPLE_WIDTH + 2;
  localparam int ACC_W  = DATA_W + 3;
  localparam int LOW_W  = DATA_W;
  localparam int PROD_W = ACC_W + LOW_W;
  localparam int CNT_W  = $clog2(LOW_W);
  localparam int N_STEP = STEP_W + 1;
  localparam int N_INT  = DATA_W;
  localparam int N_PD   = DERR_W;
  localparam int SHL    = (FRACTION_BITS >= STEP_W) ? FRACTION_BITS - STEP_W : 0;
  localparam int SHR    = (FRACTION_BITS <  STEP_W) ? STEP_W - FRACTION_BITS : 0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_STEP,
    S_INT_ADD,
    S_INT_CLAMP,
    S_MUL_INT,
    S_TERM,
    S_MUL_PD,
    S_SUM,
    S_SAT
  } state_e;

  function automatic logic signed [DATA_W-1:0] clamp_lim(
    input logic signed [PROD_W-1:0] v,
    input logic signed [DATA_W-1:0] lo,
    input logic signed [DATA_W-1:0] hi
  );
    logic signed [DATA_W-1:0] r;
    if (v < PROD_W'(lo)) begin
      r = lo;
    end else if (v > PROD_W'(hi)) begin
      r = hi;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic signed [DATA_W-1:0] kp_q, kp_d, ki_q, ki_d, kd_q, kd_d;
  logic signed [DATA_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic        [STEP_W-1:0] step_q, step_d;

  logic        [SAMPLE_WIDTH-1:0] last_target_q, last_target_d;
  logic signed [ERR_W-1:0]        prev_err_q, prev_err_d;
  logic signed [DATA_W-1:0]       integral_q, integral_d;
  logic signed [ERR_W-1:0]        err_q, err_d;
  logic signed [DERR_W-1:0]       derr_q, derr_d;

  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic        [LOW_W-1:0]  low_q, low_d;
  logic signed [DATA_W-1:0] m1_q, m1_d, m2_q, m2_d;
  logic        [LOW_W-1:0]  b1_q, b1_d, b2_q, b2_d;
  logic        [CNT_W-1:0]  cnt_q, cnt_d;

  logic signed [PROD_W-1:0] sum_q, sum_d, term_q, term_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] drive_q, drive_d;

  logic signed [SAMPLE_WIDTH-1:0] tgt_s, meas_s;
  logic                           tgt_changed;
  logic signed [ERR_W-1:0]        prev_eff, err_new;
  logic signed [DERR_W-1:0]       derr_new;
  logic signed [ACC_W-1:0]        add1, add2, acc_sum;
  logic                           mul_last;
  logic signed [PROD_W-1:0]       prod_full, prod_step, prod_pd, inc, sat_val;
  logic signed [DATA_W-1:0]       integ_clamped;
  logic                           out_free;

  assign tgt_s       = sample_i.target;
  assign meas_s      = sample_i.measured;
  assign tgt_changed = sample_i.target != last_target_q;
  assign prev_eff    = tgt_changed ? '0 : prev_err_q;
  assign err_new     = ERR_W'(tgt_s) - ERR_W'(meas_s);
  assign derr_new    = DERR_W'(err_new) - DERR_W'(prev_eff);

  assign mul_last = cnt_q == '0;
  assign add1     = b1_q[0] ? ACC_W'(m1_q) : '0;
  assign add2     = b2_q[0] ? ACC_W'(m2_q) : '0;
  assign acc_sum  = mul_last ? (acc_q - add1 - add2) : (acc_q + add1 + add2);

  assign prod_full = {acc_q, low_q};
  assign prod_step = prod_full >>> (LOW_W - N_STEP);
  assign prod_pd   = prod_full >>> (LOW_W - N_PD);
  assign inc       = (FRACTION_BITS >= STEP_W) ? (prod_step <<< SHL) : (prod_step >>> SHR);

  assign integ_clamped = clamp_lim(sum_q, lo_q, hi_q);
  assign sat_val = (sum_q > PROD_W'(pidpc_pkg::DATA_MAX)) ? PROD_W'(pidpc_pkg::DATA_MAX) :
                   (sum_q < PROD_W'(pidpc_pkg::DATA_MIN)) ? PROD_W'(pidpc_pkg::DATA_MIN) :
                   sum_q;

  assign out_free = !out_valid_q || result_o.ready;

  assign sample_i.ready = state_q == S_IDLE;
  assign result_o.valid = out_valid_q;
  assign result_o.drive = drive_q;

  always_comb begin
    state_d       = state_q;
    kp_d          = kp_q;
    ki_d          = ki_q;
    kd_d          = kd_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    step_d        = step_q;
    last_target_d = last_target_q;
    prev_err_d    = prev_err_q;
    integral_d    = integral_q;
    err_d         = err_q;
    derr_d        = derr_q;
    acc_d         = acc_q;
    low_d         = low_q;
    m1_d          = m1_q;
    m2_d          = m2_q;
    b1_d          = b1_q;
    b2_d          = b2_q;
    cnt_d         = cnt_q;
    sum_d         = sum_q;
    term_d        = term_q;
    drive_d       = drive_q;
    out_valid_d   = out_valid_q && !result_o.ready;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        pidpc_pkg::REG_GAIN_P:    kp_d   = cfg_data_i;
        pidpc_pkg::REG_GAIN_I:    ki_d   = cfg_data_i;
        pidpc_pkg::REG_GAIN_D:    kd_d   = cfg_data_i;
        pidpc_pkg::REG_STEP_TIME: step_d = cfg_data_i[STEP_W-1:0];
        pidpc_pkg::REG_LOWER:     lo_d   = cfg_data_i;
        pidpc_pkg::REG_UPPER:     hi_d   = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (sample_i.valid) begin
          last_target_d = sample_i.target;
          prev_err_d    = err_new;
          err_d         = err_new;
          derr_d        = derr_new;
          if (tgt_changed) begin
            integral_d = '0;
          end
          acc_d   = '0;
          low_d   = '0;
          m1_d    = DATA_W'(err_new);
          m2_d    = '0;
          b1_d    = LOW_W'(step_q);
          b2_d    = '0;
          cnt_d   = CNT_W'(N_STEP - 1);
          state_d = S_MUL_STEP;
        end
      end
      S_MUL_STEP, S_MUL_INT, S_MUL_PD: begin
        acc_d = acc_sum >>> 1;
        low_d = {acc_sum[0], low_q[LOW_W-1:1]};
        b1_d  = b1_q >> 1;
        b2_d  = b2_q >> 1;
        cnt_d = cnt_q - 1'b1;
        if (mul_last) begin
          case (state_q)
            S_MUL_STEP: state_d = S_INT_ADD;
            S_MUL_INT:  state_d = S_TERM;
            default:    state_d = S_SUM;
          endcase
        end
      end
      S_INT_ADD: begin
        sum_d   = PROD_W'(integral_q) + inc;
        state_d = S_INT_CLAMP;
      end
      S_INT_CLAMP: begin
        integral_d = integ_clamped;
        acc_d      = '0;
        low_d      = '0;
        m1_d       = ki_q;
        m2_d       = '0;
        b1_d       = LOW_W'(integ_clamped);
        b2_d       = '0;
        cnt_d      = CNT_W'(N_INT - 1);
        state_d    = S_MUL_INT;
      end
      S_TERM: begin
        term_d  = prod_full >>> FRACTION_BITS;
        acc_d   = '0;
        low_d   = '0;
        m1_d    = kp_q;
        m2_d    = kd_q;
        b1_d    = LOW_W'(err_q);
        b2_d    = LOW_W'(derr_q);
        cnt_d   = CNT_W'(N_PD - 1);
        state_d = S_MUL_PD;
      end
      S_SUM: begin
        sum_d   = term_q + prod_pd;
        state_d = S_SAT;
      end
      S_SAT: begin
        if (out_free) begin
          drive_d     = clamp_lim(sat_val, lo_q, hi_q);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      kp_q          <= '0;
      ki_q          <= '0;
      kd_q          <= '0;
      step_q        <= pidpc_pkg::STEP_TIME_RST;
      lo_q          <= pidpc_pkg::DATA_MIN;
      hi_q          <= pidpc_pkg::DATA_MAX;
      last_target_q <= '0;
      prev_err_q    <= '0;
      integral_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      kp_q          <= kp_d;
      ki_q          <= ki_d;
      kd_q          <= kd_d;
      step_q        <= step_d;
      lo_q          <= lo_d;
      hi_q          <= hi_d;
      last_target_q <= last_target_d;
      prev_err_q    <= prev_err_d;
      integral_q    <= integral_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q   <= err_d;
    derr_q  <= derr_d;
    acc_q   <= acc_d;
    low_q   <= low_d;
    m1_q    <= m1_d;
    m2_q    <= m2_d;
    b1_q    <= b1_d;
    b2_q    <= b2_d;
    cnt_q   <= cnt_d;
    sum_q   <= sum_d;
    term_q  <= term_d;
    drive_q <= drive_d;
  end

endmodule
